@@ design/gdss_pkg.sv @@
// shared types and constants for the glyph double-size smoother
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package gdss_pkg;

   localparam int COLUMN_W      = 8;
   localparam int WORD_W        = 16;
   localparam int INDEX_W       = 8;
   localparam logic [INDEX_W-1:0] GLYPH_WIDTH_RESET = 8'd8;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QUEUE_PTR_W-1:0] QUEUE_PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] QUEUE_CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   // byte positions of one column's output sequence
   typedef logic [2:0] step_type;
   localparam step_type STEP_SMOOTH_LO = 3'd0;
   localparam step_type STEP_SMOOTH_HI = 3'd1;
   localparam step_type STEP_WORD_LO   = 3'd2;
   localparam step_type STEP_WORD_HI   = 3'd3;
   localparam step_type STEP_ZERO_LO   = 3'd4;
   localparam step_type STEP_ZERO_HI   = 3'd5;

   typedef struct packed {
      logic [WORD_W-1:0] smooth_word;
      logic [WORD_W-1:0] column_word;
      logic              first;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ design/gdss_if.sv @@
// handshake channels of the smoother: column input and result byte output
// depends on gdss_pkg for field widths
`timescale 1ns / 1ps

interface gdss_req_if;
   logic                            valid;
   logic                            ready;
   logic [gdss_pkg::COLUMN_W-1:0]   column_byte;

   modport source (output valid, output column_byte, input ready);
   modport sink   (input valid, input column_byte, output ready);
endinterface

interface gdss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       transaction_end;
   logic       run_last;

   modport source (output valid, output data_byte, output transaction_end,
                   output run_last, input ready);
   modport sink   (input valid, input data_byte, input transaction_end,
                   input run_last, output ready);
endinterface

@@ design/gdss_front.sv @@
// front end: accepts column bytes, widens and smooths, tracks glyph position
// depends on gdss_pkg and gdss_if; feeds commands to gdss_queue
`timescale 1ns / 1ps

module gdss_front (
   input  logic                              clock,
   input  logic                              reset,
   gdss_req_if.sink                          req,
   input  logic                              csr_we,
   input  logic [gdss_pkg::INDEX_W-1:0]      csr_wdata,
   input  gdss_pkg::queue_status_type        q_status,
   output logic                              push,
   output gdss_pkg::cmd_type                 push_cmd
);

   logic [gdss_pkg::INDEX_W-1:0] glyph_width_ff, glyph_width_in;
   logic [gdss_pkg::INDEX_W-1:0] column_index_ff, column_index_in;
   logic [gdss_pkg::WORD_W-1:0]  previous_word_ff, previous_word_in;
   logic [gdss_pkg::WORD_W-1:0]  w;
   logic [gdss_pkg::WORD_W-1:0]  y;
   logic [gdss_pkg::WORD_W-1:0]  p;
   logic [gdss_pkg::WORD_W-1:0]  diag;
   logic                         first;
   logic                         last;

   assign req.ready = !q_status.full;
   assign push      = req.valid && req.ready;

   // spread bits to even positions, fill odd ones between set pairs
   always_comb begin
      y = '0;
      for (int i = 0; i < gdss_pkg::COLUMN_W; i++) begin
         y[2*i] = req.column_byte[i];
      end
      w = y | ({y[gdss_pkg::WORD_W-2:0], 1'b0} & {1'b0, y[gdss_pkg::WORD_W-1:1]});
   end

   assign p    = previous_word_ff;
   assign diag = ({1'b0, p[gdss_pkg::WORD_W-1:1]} & {w[gdss_pkg::WORD_W-2:0], 1'b0})
               | ({p[gdss_pkg::WORD_W-2:0], 1'b0} & {1'b0, w[gdss_pkg::WORD_W-1:1]});

   assign first = (column_index_ff == '0);
   assign last  = (glyph_width_ff <= 8'd1)
               || (({1'b0, column_index_ff} + 9'd1) >= {1'b0, glyph_width_ff});

   always_comb begin
      push_cmd.smooth_word = (p & w) | (~(p | w) & diag);
      push_cmd.column_word = w;
      push_cmd.first       = first;
      push_cmd.last        = last;
   end

   always_comb begin
      glyph_width_in   = csr_we ? csr_wdata : glyph_width_ff;
      column_index_in  = column_index_ff;
      previous_word_in = previous_word_ff;
      if (push) begin
         column_index_in  = last ? '0 : column_index_ff + 8'd1;
         previous_word_in = w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff   <= gdss_pkg::GLYPH_WIDTH_RESET;
         column_index_ff  <= '0;
         previous_word_ff <= '0;
      end else begin
         glyph_width_ff   <= glyph_width_in;
         column_index_ff  <= column_index_in;
         previous_word_ff <= previous_word_in;
      end
   end

endmodule

@@ design/gdss_queue.sv @@
// short command queue between front and back end
// depends on gdss_pkg
`timescale 1ns / 1ps

module gdss_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gdss_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output gdss_pkg::cmd_type          pop_cmd,
   output gdss_pkg::queue_status_type status
);

   gdss_pkg::cmd_type                entry_ff [gdss_pkg::QUEUE_DEPTH];
   logic [gdss_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gdss_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gdss_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == gdss_pkg::QUEUE_CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == gdss_pkg::QUEUE_PTR_LAST) ? '0
                   : wr_ptr_ff + gdss_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == gdss_pkg::QUEUE_PTR_LAST) ? '0
                   : rd_ptr_ff + gdss_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + gdss_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - gdss_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/gdss_back.sv @@
// back end: walks each command through its bytes into the result register
// depends on gdss_pkg and gdss_if; drains gdss_queue
`timescale 1ns / 1ps

module gdss_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gdss_pkg::cmd_type          cmd,
   input  gdss_pkg::queue_status_type q_status,
   output logic                       pop,
   gdss_rsp_if.source                 rsp
);

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           data_ff, data_in;
   logic                 tend_ff, tend_in;
   logic                 rlast_ff, rlast_in;
   logic                 active_ff, active_in;
   gdss_pkg::step_type   step_ff, step_in;
   gdss_pkg::step_type   cur_step;
   gdss_pkg::step_type   end_step;
   logic                 load;

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.data_byte       = data_ff;
   assign rsp.transaction_end = tend_ff;
   assign rsp.run_last        = rlast_ff;

   assign load     = !rsp_valid_ff || rsp.ready;
   assign cur_step = active_ff ? step_ff
                   : (cmd.first ? gdss_pkg::STEP_WORD_LO : gdss_pkg::STEP_SMOOTH_LO);
   assign end_step = cmd.last ? gdss_pkg::STEP_ZERO_HI : gdss_pkg::STEP_WORD_HI;
   assign pop      = load && !q_status.empty && (cur_step == end_step);

   always_comb begin
      data_in      = data_ff;
      tend_in      = tend_ff;
      rlast_in     = rlast_ff;
      rsp_valid_in = rsp_valid_ff;
      active_in    = active_ff;
      step_in      = step_ff;
      if (load) begin
         rsp_valid_in = !q_status.empty;
         unique case (cur_step)
            gdss_pkg::STEP_SMOOTH_LO: data_in = cmd.smooth_word[7:0];
            gdss_pkg::STEP_SMOOTH_HI: data_in = cmd.smooth_word[15:8];
            gdss_pkg::STEP_WORD_LO:   data_in = cmd.column_word[7:0];
            gdss_pkg::STEP_WORD_HI:   data_in = cmd.column_word[15:8];
            default:                  data_in = '0;
         endcase
         tend_in  = (cur_step == gdss_pkg::STEP_WORD_HI)
                 || (cur_step == gdss_pkg::STEP_ZERO_HI);
         rlast_in = (cur_step == end_step);
         if (!q_status.empty) begin
            active_in = (cur_step != end_step);
            step_in   = cur_step + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         step_ff      <= gdss_pkg::STEP_SMOOTH_LO;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      tend_ff  <= tend_in;
      rlast_ff <= rlast_in;
   end

endmodule

@@ design/glyph_double_size_smoother.sv @@
// top level of the glyph double-size smoother
// depends on gdss_pkg, gdss_if, gdss_front, gdss_queue, gdss_back
//
// use: column bytes of a glyph enter on req (valid/ready, column_byte), in
// column order. each column gives result words on rsp (data_byte,
// transaction_end, run_last), one byte per cycle while rsp is ready: the
// first column of a glyph gives 2 bytes, later columns 4, and the last
// column 2 more zero bytes, so 2 to 6 bytes per column, through the single
// result byte register; the front takes the next column while the back
// still drains. a column goes to a queue entry, then its first byte to the
// result register. csr_we/csr_wdata load glyph_width; write it only
// while idle. reset (synchronous) empties the queue, sets glyph_width to 8,
// the column position to glyph start and the previous word to zero. when
// rsp stalls, the result byte holds; the queue fills and req.ready drops.
`timescale 1ns / 1ps

module glyph_double_size_smoother (
   input  logic                         clock,
   input  logic                         reset,
   gdss_req_if.sink                     req,
   gdss_rsp_if.source                   rsp,
   input  logic                         csr_we,
   input  logic [gdss_pkg::INDEX_W-1:0] csr_wdata
);

   gdss_pkg::cmd_type          push_cmd;
   gdss_pkg::cmd_type          pop_cmd;
   gdss_pkg::queue_status_type q_status;
   logic                       push;
   logic                       pop;

   gdss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   gdss_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   gdss_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (pop_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue pushed while full");

   a_run_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.run_last) |-> rsp.transaction_end)
      else $error("run_last word without transaction_end");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp.valid && q_status.empty))
      else $error("result or queue not idle after reset");

endmodule
